>>> sv/tnpf_pkg.sv
// Shared constants and types of the track neighborhood point filter.
package tnpf_pkg;

    localparam int COORD_WIDTH_DEFAULT = 32;
    localparam int ID_WIDTH            = 32;
    localparam int DIR_WIDTH           = 21;
    localparam int BWF_WIDTH           = 21;
    localparam int PACKED_WIDTH        = 63;
    localparam int LENGTH_WIDTH        = 32;
    localparam int CFG_INDEX_WIDTH     = 3;
    localparam int CFG_DATA_WIDTH      = 64;
    localparam int EXT_ROUND_SHIFT     = 19;
    localparam int RADIUS_SHIFT        = 38;
    localparam int MAG_SPLIT           = 21;
    localparam int MAG_LIMIT           = 41;
    localparam int PIPE_STAGES         = 8;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_EVENT_KIND   = 3'd0,
        REG_ORIGIN_X     = 3'd1,
        REG_ORIGIN_Y     = 3'd2,
        REG_ORIGIN_Z     = 3'd3,
        REG_DIRECTION    = 3'd4,
        REG_BANDWIDTH    = 3'd5,
        REG_TRACK_LENGTH = 3'd6
    } cfg_reg_t;

    localparam logic EVENT_TRACK = 1'b1;

endpackage

>>> sv/track_neighborhood_point_filter_unit.sv
// Top level of the track neighborhood point filter: box test and track distance test.
//
// The block tests one point per transfer against a neighborhood set up by the
// configuration registers. Points arrive on the s_ channel, one result per point
// leaves on the m_ channel in the same order. Registers are written through the
// cfg_ channel, which is always ready; write them only while no point is in flight.
//
// The path from the input transfer to the output transfer runs through the eight
// register stages: capture with the track extension products, bounds and offsets,
// box compare with the cross products, cross differences, magnitudes, split squaring,
// square assembly, and the final compare. Throughput is one point per clock cycle
// while the receiver keeps m_tready high.
//
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_tready drops, so nothing is lost or repeated. Reset clears the configuration
// registers and the valid bits of every stage, so no result is shown after reset.
module track_neighborhood_point_filter_unit #(
    parameter int COORD_WIDTH = tnpf_pkg::COORD_WIDTH_DEFAULT,
    localparam int InTdataWidth = ((3 * COORD_WIDTH + tnpf_pkg::ID_WIDTH + 7) / 8) * 8,
    localparam int OutTdataWidth = ((tnpf_pkg::ID_WIDTH + 2 + 7) / 8) * 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0: point_x, point_y, point_z, point_id.
    input  logic [InTdataWidth-1:0]                s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Fields from bit 0: result_id, in_box, within_radius.
    output logic [OutTdataWidth-1:0]               m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tnpf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [tnpf_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    localparam int W     = COORD_WIDTH;
    localparam int IDW   = tnpf_pkg::ID_WIDTH;
    localparam int DW    = tnpf_pkg::DIR_WIDTH;
    localparam int HW    = tnpf_pkg::BWF_WIDTH;
    localparam int TW    = W + 1;
    localparam int PW    = W + DW + 1;
    localparam int CW    = PW + 1;
    localparam int MW    = (CW > tnpf_pkg::MAG_LIMIT + 1) ? CW : tnpf_pkg::MAG_LIMIT + 1;
    localparam int LW    = tnpf_pkg::MAG_SPLIT;
    localparam int HIW   = tnpf_pkg::MAG_LIMIT - tnpf_pkg::MAG_SPLIT;
    localparam int EPW   = tnpf_pkg::LENGTH_WIDTH + DW;
    localparam int EXTW  = EPW - tnpf_pkg::EXT_ROUND_SHIFT + 1;
    localparam int BDW   = ((W > EXTW) ? W : EXTW) + 3;
    localparam int HSQW  = 2 * HW;
    localparam int HSW   = HSQW + 2;
    localparam int SQW   = 2 * tnpf_pkg::MAG_LIMIT;
    localparam int SUMW  = SQW + 2;
    localparam int NS    = tnpf_pkg::PIPE_STAGES;

    // Configuration registers.
    logic                                  kind_reg;
    logic signed [W-1:0]                   origin_reg [3];
    logic [tnpf_pkg::PACKED_WIDTH-1:0]     dir_reg;
    logic [tnpf_pkg::PACKED_WIDTH-1:0]     bw_reg;
    logic [tnpf_pkg::LENGTH_WIDTH-1:0]     len_reg;

    logic signed [DW-1:0]                  dir_f   [3];
    logic [DW-1:0]                         dir_mag [3];
    logic [HW-1:0]                         bw_f    [3];

    logic                                  adv;
    logic [NS-1:0]                         vld_reg;

    // Stage 1: captured point and track extension products.
    logic signed [W-1:0]                   s1_p_next   [3];
    logic signed [W-1:0]                   s1_p_reg    [3];
    logic [EPW-1:0]                        s1_ep_next  [3];
    logic [EPW-1:0]                        s1_ep_reg   [3];
    logic [IDW-1:0]                        s1_id_reg;

    // Stage 2: offsets from the origin and box bounds.
    logic [EPW:0]                          ext_sum     [3];
    logic [EXTW-1:0]                       ext_mag     [3];
    logic signed [BDW-1:0]                 ext_s       [3];
    logic signed [BDW-1:0]                 bw_s        [3];
    logic signed [TW-1:0]                  s2_t_next   [3];
    logic signed [TW-1:0]                  s2_t_reg    [3];
    logic signed [BDW-1:0]                 s2_lo_next  [3];
    logic signed [BDW-1:0]                 s2_lo_reg   [3];
    logic signed [BDW-1:0]                 s2_hi_next  [3];
    logic signed [BDW-1:0]                 s2_hi_reg   [3];
    logic signed [W-1:0]                   s2_p_reg    [3];
    logic [IDW-1:0]                        s2_id_reg;

    // Stage 3: box verdict, cross product terms and bandwidth squares.
    logic                                  s3_inb_next;
    logic                                  s3_inb_reg;
    logic signed [PW-1:0]                  s3_prod_next [6];
    logic signed [PW-1:0]                  s3_prod_reg  [6];
    logic [HSQW-1:0]                       s3_hsq_next  [3];
    logic [HSQW-1:0]                       s3_hsq_reg   [3];
    logic [IDW-1:0]                        s3_id_reg;

    // Stage 4: cross product components and the bandwidth square sum.
    logic signed [CW-1:0]                  s4_c_next   [3];
    logic signed [CW-1:0]                  s4_c_reg    [3];
    logic [HSW-1:0]                        s4_hs_next;
    logic [HSW-1:0]                        s4_hs_reg;
    logic                                  s4_inb_reg;
    logic [IDW-1:0]                        s4_id_reg;

    // Stage 5: component magnitudes and the out-of-range flag.
    logic [CW-1:0]                         c_abs       [3];
    logic [MW-1:0]                         c_wide      [3];
    logic [tnpf_pkg::MAG_LIMIT-1:0]        s5_mag_next [3];
    logic [tnpf_pkg::MAG_LIMIT-1:0]        s5_mag_reg  [3];
    logic                                  s5_big_next;
    logic                                  s5_big_reg;
    logic [HSW-1:0]                        s5_hs_reg;
    logic                                  s5_inb_reg;
    logic [IDW-1:0]                        s5_id_reg;

    // Stage 6: partial products of the squares.
    logic [2*HIW-1:0]                      s6_hh_next  [3];
    logic [2*HIW-1:0]                      s6_hh_reg   [3];
    logic [HIW+LW-1:0]                     s6_hl_next  [3];
    logic [HIW+LW-1:0]                     s6_hl_reg   [3];
    logic [2*LW-1:0]                       s6_ll_next  [3];
    logic [2*LW-1:0]                       s6_ll_reg   [3];
    logic                                  s6_big_reg;
    logic [HSW-1:0]                        s6_hs_reg;
    logic                                  s6_inb_reg;
    logic [IDW-1:0]                        s6_id_reg;

    // Stage 7: assembled squares.
    logic [SQW-1:0]                        s7_sq_next  [3];
    logic [SQW-1:0]                        s7_sq_reg   [3];
    logic                                  s7_big_reg;
    logic [HSW-1:0]                        s7_hs_reg;
    logic                                  s7_inb_reg;
    logic [IDW-1:0]                        s7_id_reg;

    // Stage 8: result register.
    logic [SUMW-1:0]                       lhs_sum;
    logic [SUMW-1:0]                       rhs_val;
    logic                                  s8_near_next;
    logic                                  s8_near_reg;
    logic                                  s8_inb_reg;
    logic [IDW-1:0]                        s8_id_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                origin_reg[k] <= '0;
            end
            dir_reg <= '0;
            bw_reg  <= '0;
            len_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (tnpf_pkg::cfg_reg_t'(cfg_index))
                tnpf_pkg::REG_EVENT_KIND:   kind_reg      <= cfg_data[0];
                tnpf_pkg::REG_ORIGIN_X:     origin_reg[0] <= cfg_data[W-1:0];
                tnpf_pkg::REG_ORIGIN_Y:     origin_reg[1] <= cfg_data[W-1:0];
                tnpf_pkg::REG_ORIGIN_Z:     origin_reg[2] <= cfg_data[W-1:0];
                tnpf_pkg::REG_DIRECTION:    dir_reg <= cfg_data[tnpf_pkg::PACKED_WIDTH-1:0];
                tnpf_pkg::REG_BANDWIDTH:    bw_reg  <= cfg_data[tnpf_pkg::PACKED_WIDTH-1:0];
                tnpf_pkg::REG_TRACK_LENGTH: len_reg <= cfg_data[tnpf_pkg::LENGTH_WIDTH-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dir_f[k]   = $signed(dir_reg[DW*k +: DW]);
            dir_mag[k] = dir_f[k][DW-1] ? (DW'(0) - dir_reg[DW*k +: DW]) : dir_reg[DW*k +: DW];
            bw_f[k]    = bw_reg[HW*k +: HW];
        end
    end

    assign adv      = !vld_reg[NS-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_p_next[k]  = $signed(s_tdata[W*k +: W]);
            s1_ep_next[k] = EPW'(len_reg) * EPW'(dir_mag[k]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ext_sum[k] = (EPW+1)'(s1_ep_reg[k])
                       + ((EPW+1)'(1) << (tnpf_pkg::EXT_ROUND_SHIFT - 1));
            ext_mag[k] = ext_sum[k][EPW:tnpf_pkg::EXT_ROUND_SHIFT];
            ext_s[k]   = $signed(BDW'(ext_mag[k]));
            bw_s[k]    = $signed(BDW'(bw_f[k]));
            s2_t_next[k]  = TW'(s1_p_reg[k]) - TW'(origin_reg[k]);
            s2_lo_next[k] = BDW'(origin_reg[k]) - bw_s[k];
            s2_hi_next[k] = BDW'(origin_reg[k]) + bw_s[k];
            if (kind_reg == tnpf_pkg::EVENT_TRACK)
            begin
                if (dir_f[k][DW-1])
                begin
                    s2_lo_next[k] = s2_lo_next[k] - ext_s[k];
                end
                else if (|dir_f[k])
                begin
                    s2_hi_next[k] = s2_hi_next[k] + ext_s[k];
                end
            end
        end
    end

    always_comb
    begin
        s3_inb_next = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            if (BDW'(s2_p_reg[k]) < s2_lo_reg[k] || BDW'(s2_p_reg[k]) > s2_hi_reg[k])
            begin
                s3_inb_next = 1'b0;
            end
            s3_hsq_next[k] = HSQW'(bw_f[k]) * HSQW'(bw_f[k]);
        end
        s3_prod_next[0] = PW'(dir_f[1]) * PW'(s2_t_reg[2]);
        s3_prod_next[1] = PW'(dir_f[2]) * PW'(s2_t_reg[1]);
        s3_prod_next[2] = PW'(dir_f[2]) * PW'(s2_t_reg[0]);
        s3_prod_next[3] = PW'(dir_f[0]) * PW'(s2_t_reg[2]);
        s3_prod_next[4] = PW'(dir_f[0]) * PW'(s2_t_reg[1]);
        s3_prod_next[5] = PW'(dir_f[1]) * PW'(s2_t_reg[0]);
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s4_c_next[k] = CW'(s3_prod_reg[2*k]) - CW'(s3_prod_reg[2*k+1]);
        end
        s4_hs_next = HSW'(s3_hsq_reg[0]) + HSW'(s3_hsq_reg[1]) + HSW'(s3_hsq_reg[2]);
    end

    always_comb
    begin
        s5_big_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            c_abs[k]  = s4_c_reg[k][CW-1] ? (CW'(0) - CW'(s4_c_reg[k])) : CW'(s4_c_reg[k]);
            c_wide[k] = MW'(c_abs[k]);
            s5_mag_next[k] = c_wide[k][tnpf_pkg::MAG_LIMIT-1:0];
            if (|c_wide[k][MW-1:tnpf_pkg::MAG_LIMIT])
            begin
                s5_big_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s6_hh_next[k] = (2*HIW)'(s5_mag_reg[k][tnpf_pkg::MAG_LIMIT-1:LW])
                          * (2*HIW)'(s5_mag_reg[k][tnpf_pkg::MAG_LIMIT-1:LW]);
            s6_hl_next[k] = (HIW+LW)'(s5_mag_reg[k][tnpf_pkg::MAG_LIMIT-1:LW])
                          * (HIW+LW)'(s5_mag_reg[k][LW-1:0]);
            s6_ll_next[k] = (2*LW)'(s5_mag_reg[k][LW-1:0])
                          * (2*LW)'(s5_mag_reg[k][LW-1:0]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s7_sq_next[k] = (SQW'(s6_hh_reg[k]) << (2 * LW))
                          + (SQW'(s6_hl_reg[k]) << (LW + 1))
                          + SQW'(s6_ll_reg[k]);
        end
    end

    always_comb
    begin
        lhs_sum = SUMW'(s7_sq_reg[0]) + SUMW'(s7_sq_reg[1]) + SUMW'(s7_sq_reg[2]);
        rhs_val = SUMW'(s7_hs_reg) << tnpf_pkg::RADIUS_SHIFT;
        s8_near_next = (kind_reg == tnpf_pkg::EVENT_TRACK) && !s7_big_reg && (lhs_sum < rhs_val);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_p_reg[k]   <= s1_p_next[k];
                s1_ep_reg[k]  <= s1_ep_next[k];
                s2_t_reg[k]   <= s2_t_next[k];
                s2_lo_reg[k]  <= s2_lo_next[k];
                s2_hi_reg[k]  <= s2_hi_next[k];
                s2_p_reg[k]   <= s1_p_reg[k];
                s3_hsq_reg[k] <= s3_hsq_next[k];
                s4_c_reg[k]   <= s4_c_next[k];
                s5_mag_reg[k] <= s5_mag_next[k];
                s6_hh_reg[k]  <= s6_hh_next[k];
                s6_hl_reg[k]  <= s6_hl_next[k];
                s6_ll_reg[k]  <= s6_ll_next[k];
                s7_sq_reg[k]  <= s7_sq_next[k];
            end
            for (int j = 0; j < 6; j++)
            begin
                s3_prod_reg[j] <= s3_prod_next[j];
            end
            s1_id_reg   <= s_tdata[3*W +: IDW];
            s2_id_reg   <= s1_id_reg;
            s3_id_reg   <= s2_id_reg;
            s4_id_reg   <= s3_id_reg;
            s5_id_reg   <= s4_id_reg;
            s6_id_reg   <= s5_id_reg;
            s7_id_reg   <= s6_id_reg;
            s8_id_reg   <= s7_id_reg;
            s3_inb_reg  <= s3_inb_next;
            s4_inb_reg  <= s3_inb_reg;
            s5_inb_reg  <= s4_inb_reg;
            s6_inb_reg  <= s5_inb_reg;
            s7_inb_reg  <= s6_inb_reg;
            s8_inb_reg  <= s7_inb_reg;
            s4_hs_reg   <= s4_hs_next;
            s5_hs_reg   <= s4_hs_reg;
            s6_hs_reg   <= s5_hs_reg;
            s7_hs_reg   <= s6_hs_reg;
            s5_big_reg  <= s5_big_next;
            s6_big_reg  <= s5_big_reg;
            s7_big_reg  <= s6_big_reg;
            s8_near_reg <= s8_near_next;
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = OutTdataWidth'({s8_near_reg, s8_inb_reg, s8_id_reg});

    a_near_needs_track: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[IDW+1]) |-> (kind_reg == tnpf_pkg::EVENT_TRACK))
        else $error("within_radius set while the event is a collision");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved while the result was stalled");

    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted transfer did not enter the first stage");

    a_far_not_near: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s7_big_reg) |=> !s8_near_reg)
        else $error("out of range cross product reported as within radius");

endmodule

>>> tb/tnpf_checker.sv
`timescale 1ns / 100ps
// Checker for the track neighborhood point filter: predicts each result and compares it.
module tnpf_checker #(
    parameter int COORD_WIDTH = tnpf_pkg::COORD_WIDTH_DEFAULT,
    localparam int InTdataWidth = ((3 * COORD_WIDTH + tnpf_pkg::ID_WIDTH + 7) / 8) * 8,
    localparam int OutTdataWidth = ((tnpf_pkg::ID_WIDTH + 2 + 7) / 8) * 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    input  logic                                   s_tready,
    // Fields from bit 0: point_x, point_y, point_z, point_id.
    input  logic [InTdataWidth-1:0]                s_tdata,
    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Fields from bit 0: result_id, in_box, within_radius.
    input  logic [OutTdataWidth-1:0]               m_tdata,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [tnpf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [tnpf_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    output int                                     fail_count,
    output int                                     pending
);

    localparam int IDW = tnpf_pkg::ID_WIDTH;
    localparam int DW  = tnpf_pkg::DIR_WIDTH;
    localparam int HW  = tnpf_pkg::BWF_WIDTH;

    typedef struct {
        logic [IDW-1:0] id;
        logic           in_box;
        logic           within_radius;
    } point_verdict_t;

    point_verdict_t awaited_results[$];

    logic                                event_kind = 1'b0;
    logic signed [COORD_WIDTH-1:0]       origin[3] = '{default: '0};
    logic [tnpf_pkg::PACKED_WIDTH-1:0]   direction_word = '0;
    logic [tnpf_pkg::PACKED_WIDTH-1:0]   bandwidth_word = '0;
    logic [tnpf_pkg::LENGTH_WIDTH-1:0]   track_len = '0;

    int errors = 0;
    int in_flight = 0;

    assign fail_count = errors;
    assign pending = in_flight;

    function automatic point_verdict_t classify_point(input logic [InTdataWidth-1:0] word);
        point_verdict_t    r;
        longint            p, o, d, lo, hi, ext, hs;
        longint            h[3];
        logic [63:0]       mag;
        logic signed [127:0] wd[3];
        logic signed [127:0] wt[3];
        logic signed [127:0] cx, cy, cz, lhs, rhs;
        r.in_box = 1'b1;
        r.within_radius = 1'b0;
        r.id = word[3 * COORD_WIDTH +: IDW];
        for (int k = 0; k < 3; k++)
        begin
            p = longint'($signed(word[k * COORD_WIDTH +: COORD_WIDTH]));
            o = longint'(origin[k]);
            d = longint'($signed(direction_word[k * DW +: DW]));
            h[k] = bandwidth_word[k * HW +: HW];
            lo = o - h[k];
            hi = o + h[k];
            if (event_kind == tnpf_pkg::EVENT_TRACK && d != 0)
            begin
                mag = (d < 0) ? -d : d;
                ext = longint'((track_len * mag + (64'd1 << (tnpf_pkg::EXT_ROUND_SHIFT - 1)))
                               >> tnpf_pkg::EXT_ROUND_SHIFT);
                if (d > 0)
                    hi = hi + ext;
                else
                    lo = lo - ext;
            end
            if (p < lo || p > hi)
                r.in_box = 1'b0;
            wd[k] = d;
            wt[k] = p - o;
        end
        if (event_kind == tnpf_pkg::EVENT_TRACK)
        begin
            cx = wd[1] * wt[2] - wd[2] * wt[1];
            cy = wd[2] * wt[0] - wd[0] * wt[2];
            cz = wd[0] * wt[1] - wd[1] * wt[0];
            lhs = cx * cx + cy * cy + cz * cz;
            hs = h[0] * h[0] + h[1] * h[1] + h[2] * h[2];
            rhs = hs;
            rhs = rhs <<< tnpf_pkg::RADIUS_SHIFT;
            r.within_radius = (lhs < rhs);
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [IDW-1:0] got,
                                 input logic [IDW-1:0] want);
        if (errors < 100)
            $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        point_verdict_t want;
        if (!rst_n)
        begin
            event_kind = 1'b0;
            origin = '{default: '0};
            direction_word = '0;
            bandwidth_word = '0;
            track_len = '0;
            awaited_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                    note_mismatch("result with no point in flight", m_tdata[IDW-1:0], '0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (m_tdata[IDW-1:0] !== want.id)
                        note_mismatch("result_id", m_tdata[IDW-1:0], want.id);
                    if (m_tdata[IDW] !== want.in_box)
                        note_mismatch("in_box", m_tdata[IDW], want.in_box);
                    if (m_tdata[IDW+1] !== want.within_radius)
                        note_mismatch("within_radius", m_tdata[IDW+1], want.within_radius);
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.insert(awaited_results.size(), classify_point(s_tdata));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tnpf_pkg::REG_EVENT_KIND:   event_kind = cfg_data[0];
                    tnpf_pkg::REG_ORIGIN_X:     origin[0] = cfg_data[COORD_WIDTH-1:0];
                    tnpf_pkg::REG_ORIGIN_Y:     origin[1] = cfg_data[COORD_WIDTH-1:0];
                    tnpf_pkg::REG_ORIGIN_Z:     origin[2] = cfg_data[COORD_WIDTH-1:0];
                    tnpf_pkg::REG_DIRECTION:
                        direction_word = cfg_data[tnpf_pkg::PACKED_WIDTH-1:0];
                    tnpf_pkg::REG_BANDWIDTH:
                        bandwidth_word = cfg_data[tnpf_pkg::PACKED_WIDTH-1:0];
                    tnpf_pkg::REG_TRACK_LENGTH:
                        track_len = cfg_data[tnpf_pkg::LENGTH_WIDTH-1:0];
                    default:                    ;
                endcase
            end
        end
        in_flight = awaited_results.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for the track neighborhood point filter: stimulus, flow control and verdict.
module tb;

    localparam int CW = tnpf_pkg::COORD_WIDTH_DEFAULT;
    localparam int IDW = tnpf_pkg::ID_WIDTH;
    localparam int DW = tnpf_pkg::DIR_WIDTH;
    localparam int HW = tnpf_pkg::BWF_WIDTH;
    localparam int PKW = tnpf_pkg::PACKED_WIDTH;
    localparam int LNW = tnpf_pkg::LENGTH_WIDTH;
    localparam int CIW = tnpf_pkg::CFG_INDEX_WIDTH;
    localparam int CDW = tnpf_pkg::CFG_DATA_WIDTH;
    localparam int InTdataWidth = ((3 * CW + IDW + 7) / 8) * 8;
    localparam int OutTdataWidth = ((IDW + 2 + 7) / 8) * 8;
    localparam logic [CIW-1:0] REG_UNMAPPED = 3'd7;
    localparam int HOLD_CYCLES = 60;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [InTdataWidth-1:0]      s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [OutTdataWidth-1:0]     m_tdata;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CIW-1:0]               cfg_index;
    logic [CDW-1:0]               cfg_data;

    int     fail_count;
    int     pending;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     hold_request = 1'b0;
    longint cur_origin[3];
    longint cur_dir[3];

    track_neighborhood_point_filter_unit #(.COORD_WIDTH(CW)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    tnpf_checker #(.COORD_WIDTH(CW)) chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // The receiver stalls at random, or for a long stretch when asked to.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    task automatic cfg_write(input logic [CIW-1:0] idx,
                             input logic [CDW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Writes every register; bits above each register's width carry junk.
    task automatic configure(input logic kind, input longint ox, input longint oy,
                             input longint oz, input logic [PKW-1:0] dir,
                             input logic [PKW-1:0] bw,
                             input logic [LNW-1:0] len);
        logic [CDW-1:0] data;
        longint         org[3];
        org = '{ox, oy, oz};
        data = {$urandom(), $urandom()};
        data[0] = kind;
        cfg_write(tnpf_pkg::REG_EVENT_KIND, data);
        for (int k = 0; k < 3; k++)
        begin
            data = {$urandom(), $urandom()};
            data[CW-1:0] = org[k][CW-1:0];
            cfg_write(tnpf_pkg::cfg_reg_t'(tnpf_pkg::REG_ORIGIN_X + k), data);
            cur_origin[k] = longint'($signed(data[CW-1:0]));
            cur_dir[k] = longint'($signed(dir[k * DW +: DW]));
        end
        data = {$urandom(), $urandom()};
        data[PKW-1:0] = dir;
        cfg_write(tnpf_pkg::REG_DIRECTION, data);
        data = {$urandom(), $urandom()};
        data[PKW-1:0] = bw;
        cfg_write(tnpf_pkg::REG_BANDWIDTH, data);
        data = {$urandom(), $urandom()};
        data[LNW-1:0] = len;
        cfg_write(tnpf_pkg::REG_TRACK_LENGTH, data);
        cfg_write(REG_UNMAPPED, {$urandom(), $urandom()});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_point(input logic [CW-1:0] px, input logic [CW-1:0] py,
                              input logic [CW-1:0] pz, input logic [IDW-1:0] id);
        logic [InTdataWidth-1:0] word;
        word = '0;
        word[0 +: CW] = px;
        word[CW +: CW] = py;
        word[2 * CW +: CW] = pz;
        word[3 * CW +: IDW] = id;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= {4{$urandom()}};
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic random_config;
        logic [PKW-1:0] dir, bw;
        longint         org[3];
        for (int k = 0; k < 3; k++)
        begin
            org[k] = longint'($signed($urandom()));
            if ($urandom_range(3, 0) != 0)
                org[k] = org[k] >>> $urandom_range(30, 8);
            dir[k * DW +: DW] =
                ($urandom_range(5, 0) == 0) ? '0 : DW'($urandom());
            bw[k * HW +: HW] =
                HW'($urandom()) >> $urandom_range(12, 0);
        end
        configure($urandom_range(2, 0) != 0, org[0], org[1], org[2], dir, bw,
                  $urandom() >> $urandom_range(24, 0));
    endtask

    // Points are mostly near the box or along the track, with some anywhere.
    task automatic random_point;
        longint p[3];
        longint lam;
        int     mode;
        mode = $urandom_range(9, 0);
        lam = longint'($urandom_range(4095, 0)) - 512;
        for (int k = 0; k < 3; k++)
        begin
            if (mode < 2)
                p[k] = longint'($signed($urandom()));
            else if (mode < 6)
                p[k] = cur_origin[k] +
                       (longint'($signed($urandom())) >>> $urandom_range(31, 10));
            else
                p[k] = cur_origin[k] + ((lam * cur_dir[k]) >>> 4) +
                       (longint'($signed($urandom())) >>> $urandom_range(31, 14));
        end
        send_point(p[0][CW-1:0], p[1][CW-1:0], p[2][CW-1:0], $urandom());
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Registers at reset: a collision box of zero size at the origin.
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_point(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        drain();

        // Collision box: on and past x min, x max, y max, z min; then extremes.
        configure(1'b0, 64'sh0010_0000, -64'sh0020_0000, 64'sh0,
                  {21'h00_0000, 21'h00_0000, 21'h00_0000},
                  {21'h1F_FFFF, 21'h01_0000, 21'h00_8000}, 32'h0);
        send_point(32'h0010_8000, 32'hFFE0_0000, 32'h0000_0000, 32'd1);
        send_point(32'h0010_8001, 32'hFFE0_0000, 32'h0000_0000, 32'd2);
        send_point(32'h000F_8000, 32'hFFE0_0000, 32'h0000_0000, 32'd3);
        send_point(32'h000F_7FFF, 32'hFFE0_0000, 32'h0000_0000, 32'd4);
        send_point(32'h0010_0000, 32'hFFE1_0000, 32'h0000_0000, 32'd5);
        send_point(32'h0010_0000, 32'hFFE1_0001, 32'h0000_0000, 32'd6);
        send_point(32'h0010_0000, 32'hFFE0_0000, 32'hFFE0_0001, 32'd7);
        send_point(32'h0010_0000, 32'hFFE0_0000, 32'hFFE0_0000, 32'd8);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd9);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd10);
        drain();

        // Track: x grows the max side, y the min side, z has no extension.
        configure(1'b1, 64'sh0, 64'sh0, 64'sh0,
                  {21'h00_0000, 21'h18_0000, 21'h04_0000},
                  {21'h01_0000, 21'h01_0000, 21'h01_0000}, 32'h0002_0000);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd11);
        send_point(32'h0002_0000, 32'hFFFD_0000, 32'h0001_0000, 32'd12);
        send_point(32'h0002_0001, 32'h0000_0000, 32'h0000_0000, 32'd13);
        send_point(32'h0000_0000, 32'hFFFC_FFFF, 32'h0000_0000, 32'd14);
        send_point(32'h0001_0000, 32'hFFFE_0000, 32'h0000_0000, 32'd15);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'd16);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0002_0000, 32'd17);
        drain();

        // Extreme track: largest direction magnitudes, bandwidth and length.
        configure(1'b1, 64'sh7FFF_FFFF, -64'sh8000_0000, 64'sh7FFF_FFFF,
                  {21'h10_0000, 21'h0F_FFFF, 21'h10_0000},
                  {21'h1F_FFFF, 21'h1F_FFFF, 21'h1F_FFFF}, 32'hFFFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd18);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd19);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd20);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd21);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 32 : 0;
            for (int round = 0; round < 6; round++)
            begin
                random_config();
                if (phase == 2 && round == 2)
                    hold_request = 1'b1;
                for (int n = 0; n < 55; n++)
                begin
                    if (phase == 1 && round == 3 && n == 25)
                        drain();
                    random_point();
                end
                drain();
            end
        end

        repeat (3 * tnpf_pkg::PIPE_STAGES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
